// File: design/stkt_pkg.sv
`default_nettype none

package stkt_pkg;

  localparam int unsigned CapacityDef     = 256;
  localparam int unsigned PayloadWidthDef = 64;

  localparam int unsigned OpW     = 3;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned IdxW    = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CountW  = 9;

  typedef enum logic [OpW-1:0] {
    OP_INSERT  = 3'd0,
    OP_REMOVE  = 3'd1,
    OP_NEAREST = 3'd2,
    OP_READ    = 3'd3,
    OP_CLEAR   = 3'd4
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 3'd0,
    ST_NOT_FOUND = 3'd1,
    ST_FULL      = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_RANGE     = 3'd4
  } status_e;

endpackage

`default_nettype wire

// File: design/stkt_req_if.sv
`default_nettype none

interface stkt_req_if #(
  parameter int unsigned PW = stkt_pkg::PayloadWidthDef
);
  logic                      valid;
  logic                      ready;
  logic [stkt_pkg::OpW-1:0]  op;
  logic [stkt_pkg::KeyW-1:0] key;
  logic [PW-1:0]             payload;
  logic [stkt_pkg::IdxW-1:0] index;

  modport source (output valid, op, key, payload, index, input ready);
  modport sink   (input valid, op, key, payload, index, output ready);
endinterface

`default_nettype wire

// File: design/stkt_rsp_if.sv
`default_nettype none

interface stkt_rsp_if #(
  parameter int unsigned PW = stkt_pkg::PayloadWidthDef
);
  logic                         valid;
  logic                         ready;
  logic [stkt_pkg::StatusW-1:0] status;
  logic                         found;
  logic [stkt_pkg::KeyW-1:0]    key_out;
  logic [PW-1:0]                payload_out;
  logic [stkt_pkg::IdxW-1:0]    index_out;
  logic [stkt_pkg::CountW-1:0]  count;

  modport source (output valid, status, found, key_out, payload_out, index_out, count,
                  input ready);
  modport sink   (input valid, status, found, key_out, payload_out, index_out, count,
                  output ready);
endinterface

`default_nettype wire

// File: design/sorted_time_keyed_table.sv
`default_nettype none

// Channel  Dir  Modport               Fields
// req_i    in   stkt_req_if.sink      op, key, payload, index
// rsp_o    out  stkt_rsp_if.source    status, found, key_out, payload_out, index_out, count
//
// One transaction at a time through a single-port-read, single-port-write record memory.
// Search: each halving step reads the memory (S_SRCH), then compares keys (S_SCMP).
// Insert shifts records up (S_SHUP), then writes (S_INS); remove shifts records down (S_SHDN).
// Nearest then reads two neighbours (S_NR2, S_NR3); read by index uses S_RDW; clear goes to S_RESP.
// Reset clears the record count, state and response valid; the memory is never cleared.
// A waiting response does not block the next request; a new result waits in the
// final state until the output register is free.

module sorted_time_keyed_table #(
  parameter int unsigned CAPACITY      = stkt_pkg::CapacityDef,
  parameter int unsigned PAYLOAD_WIDTH = stkt_pkg::PayloadWidthDef
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  stkt_req_if.sink   req_i,
  stkt_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned KW = stkt_pkg::KeyW;
  localparam int unsigned IW = stkt_pkg::IdxW;
  localparam int unsigned NW = stkt_pkg::CountW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRCH = 4'd1;
  localparam logic [3:0] S_SCMP = 4'd2;
  localparam logic [3:0] S_HCMP = 4'd3;
  localparam logic [3:0] S_SHUP = 4'd4;
  localparam logic [3:0] S_SHDN = 4'd5;
  localparam logic [3:0] S_INS  = 4'd6;
  localparam logic [3:0] S_NR2  = 4'd7;
  localparam logic [3:0] S_NR3  = 4'd8;
  localparam logic [3:0] S_RDW  = 4'd9;
  localparam logic [3:0] S_RESP = 4'd10;

  // record memory
  logic [KW-1:0]            key_mem [CAPACITY];
  logic [PAYLOAD_WIDTH-1:0] pay_mem [CAPACITY];
  logic [AW-1:0]            raddr, waddr;
  logic                     we;
  logic [KW-1:0]            wkey;
  logic [PAYLOAD_WIDTH-1:0] wpay;
  logic [KW-1:0]            rd_key_q;
  logic [PAYLOAD_WIDTH-1:0] rd_pay_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      key_mem[waddr] <= wkey;
      pay_mem[waddr] <= wpay;
    end
    rd_key_q <= key_mem[raddr];
    rd_pay_q <= pay_mem[raddr];
  end

  // control and working state
  logic [3:0]               state_q, state_d;
  logic [CW-1:0]            cnt_q, cnt_d;
  logic [CW-1:0]            lo_q, lo_d, hi_q, hi_d, pos_q, pos_d, ptr_q, ptr_d;
  logic [stkt_pkg::OpW-1:0] op_q, op_d;
  logic [KW-1:0]            key_q, key_d;
  logic [PAYLOAD_WIDTH-1:0] pay_q, pay_d;
  logic [IW-1:0]            idx_q, idx_d;
  logic                     hit_q, hit_d;
  logic [KW-1:0]            kr_q, kr_d;
  logic [PAYLOAD_WIDTH-1:0] pr_q, pr_d;

  logic [stkt_pkg::StatusW-1:0] res_st_q, res_st_d;
  logic                         res_fnd_q, res_fnd_d;
  logic [KW-1:0]                res_key_q, res_key_d;
  logic [PAYLOAD_WIDTH-1:0]     res_pay_q, res_pay_d;
  logic [CW-1:0]                res_idx_q, res_idx_d;

  logic                         ovalid_q;
  logic [stkt_pkg::StatusW-1:0] ost_q;
  logic                         ofnd_q;
  logic [KW-1:0]                okey_q;
  logic [PAYLOAD_WIDTH-1:0]     opay_q;
  logic [IW-1:0]                oidx_q;
  logic [NW-1:0]                ocnt_q;
  logic                         out_load;

  // helpers
  logic [CW:0]         mid_sum;
  logic [CW-1:0]       mid;
  logic                key_lt, key_eq;
  logic [CW+IW-1:0]    idx_ext, cnt_ext;
  logic [AW+IW-1:0]    idx_addr;
  logic [CW-1:0]       cnt_m1, near_p;
  logic signed [KW+1:0] dist_l, dist_r;
  logic [CW+IW-1:0]    res_idx_ext;
  logic [CW+NW-1:0]    cnt_out_ext;

  assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid      = mid_sum[CW:1];
  assign key_lt   = rd_key_q < key_q;
  assign key_eq   = rd_key_q == key_q;
  assign idx_ext  = {{CW{1'b0}}, idx_q};
  assign cnt_ext  = {{IW{1'b0}}, cnt_q};
  assign idx_addr = {{AW{1'b0}}, req_i.index};
  assign cnt_m1   = cnt_q - CW'(1);
  assign near_p   = (lo_q == cnt_q) ? cnt_m1 : lo_q;
  assign dist_l   = $signed({2'b00, key_q}) - $signed({2'b00, rd_key_q});
  assign dist_r   = $signed({2'b00, kr_q}) - $signed({2'b00, key_q});

  assign req_i.ready = (state_q == S_IDLE);
  assign out_load    = (state_q == S_RESP) && (!ovalid_q || rsp_o.ready);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    pos_d     = pos_q;
    ptr_d     = ptr_q;
    op_d      = op_q;
    key_d     = key_q;
    pay_d     = pay_q;
    idx_d     = idx_q;
    hit_d     = hit_q;
    kr_d      = kr_q;
    pr_d      = pr_q;
    res_st_d  = res_st_q;
    res_fnd_d = res_fnd_q;
    res_key_d = res_key_q;
    res_pay_d = res_pay_q;
    res_idx_d = res_idx_q;
    raddr     = '0;
    we        = 1'b0;
    waddr     = '0;
    wkey      = key_q;
    wpay      = pay_q;

    unique case (state_q)
      S_IDLE: begin
        if (req_i.valid) begin
          op_d      = req_i.op;
          key_d     = req_i.key;
          pay_d     = req_i.payload;
          idx_d     = req_i.index;
          res_st_d  = stkt_pkg::ST_OK;
          res_fnd_d = 1'b0;
          res_key_d = '0;
          res_pay_d = '0;
          res_idx_d = '0;
          lo_d      = '0;
          hi_d      = cnt_q;
          state_d   = S_RESP;
          unique case (req_i.op)
            stkt_pkg::OP_INSERT, stkt_pkg::OP_REMOVE: state_d = S_SRCH;
            stkt_pkg::OP_NEAREST: begin
              if (cnt_q == '0) res_st_d = stkt_pkg::ST_EMPTY;
              else             state_d  = S_SRCH;
            end
            stkt_pkg::OP_READ: begin
              if (cnt_q == '0) begin
                res_st_d = stkt_pkg::ST_EMPTY;
              end else if ({{CW{1'b0}}, req_i.index} >= cnt_ext) begin
                res_st_d = stkt_pkg::ST_RANGE;
              end else begin
                raddr   = idx_addr[AW-1:0];
                state_d = S_RDW;
              end
            end
            stkt_pkg::OP_CLEAR: cnt_d = '0;
            default: ;
          endcase
        end
      end
      S_RDW: begin
        res_key_d = rd_key_q;
        res_pay_d = rd_pay_q;
        res_idx_d = idx_ext[CW-1:0];
        state_d   = S_RESP;
      end
      S_SRCH: begin
        if (lo_q < hi_q) begin
          raddr   = mid[AW-1:0];
          pos_d   = mid;
          state_d = S_SCMP;
        end else begin
          raddr   = lo_q[AW-1:0];
          state_d = S_HCMP;
        end
      end
      S_SCMP: begin
        if (key_lt) lo_d = pos_q + CW'(1);
        else        hi_d = pos_q;
        state_d = S_SRCH;
      end
      S_HCMP: begin
        hit_d   = (lo_q < cnt_q) && key_eq;
        pos_d   = lo_q;
        state_d = S_RESP;
        unique case (op_q)
          stkt_pkg::OP_INSERT: begin
            if (hit_d) begin
              we        = 1'b1;
              waddr     = lo_q[AW-1:0];
              res_fnd_d = 1'b1;
              res_idx_d = lo_q;
            end else if (cnt_q == CW'(CAPACITY)) begin
              res_st_d = stkt_pkg::ST_FULL;
            end else if (lo_q == cnt_q) begin
              state_d = S_INS;
            end else begin
              raddr   = cnt_m1[AW-1:0];
              ptr_d   = cnt_m1;
              state_d = S_SHUP;
            end
          end
          stkt_pkg::OP_REMOVE: begin
            if (!hit_d) begin
              res_st_d = stkt_pkg::ST_NOT_FOUND;
            end else if (lo_q == cnt_m1) begin
              cnt_d     = cnt_m1;
              res_fnd_d = 1'b1;
              res_idx_d = lo_q;
            end else begin
              ptr_d   = lo_q + CW'(1);
              raddr   = ptr_d[AW-1:0];
              state_d = S_SHDN;
            end
          end
          default: begin
            pos_d   = near_p;
            raddr   = near_p[AW-1:0];
            state_d = S_NR2;
          end
        endcase
      end
      S_SHUP: begin
        we    = 1'b1;
        waddr = ptr_q[AW-1:0] + AW'(1);
        wkey  = rd_key_q;
        wpay  = rd_pay_q;
        if (ptr_q == pos_q) begin
          state_d = S_INS;
        end else begin
          ptr_d = ptr_q - CW'(1);
          raddr = ptr_d[AW-1:0];
        end
      end
      S_INS: begin
        we        = 1'b1;
        waddr     = pos_q[AW-1:0];
        cnt_d     = cnt_q + CW'(1);
        res_idx_d = pos_q;
        state_d   = S_RESP;
      end
      S_SHDN: begin
        we    = 1'b1;
        waddr = ptr_q[AW-1:0] - AW'(1);
        wkey  = rd_key_q;
        wpay  = rd_pay_q;
        if (ptr_q == cnt_m1) begin
          cnt_d     = cnt_m1;
          res_fnd_d = 1'b1;
          res_idx_d = pos_q;
          state_d   = S_RESP;
        end else begin
          ptr_d = ptr_q + CW'(1);
          raddr = ptr_d[AW-1:0];
        end
      end
      S_NR2: begin
        kr_d    = rd_key_q;
        pr_d    = rd_pay_q;
        raddr   = pos_q[AW-1:0] - AW'(1);
        state_d = S_NR3;
      end
      S_NR3: begin
        res_fnd_d = hit_q;
        if ((pos_q != '0) && (dist_l < dist_r)) begin
          res_key_d = rd_key_q;
          res_pay_d = rd_pay_q;
          res_idx_d = pos_q - CW'(1);
        end else begin
          res_key_d = kr_q;
          res_pay_d = pr_q;
          res_idx_d = pos_q;
        end
        state_d = S_RESP;
      end
      S_RESP: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (out_load)         ovalid_q <= 1'b1;
      else if (rsp_o.ready) ovalid_q <= 1'b0;
    end
  end

  assign res_idx_ext = {{IW{1'b0}}, res_idx_q};
  assign cnt_out_ext = {{NW{1'b0}}, cnt_q};

  always_ff @(posedge clk_i) begin
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    pos_q     <= pos_d;
    ptr_q     <= ptr_d;
    op_q      <= op_d;
    key_q     <= key_d;
    pay_q     <= pay_d;
    idx_q     <= idx_d;
    hit_q     <= hit_d;
    kr_q      <= kr_d;
    pr_q      <= pr_d;
    res_st_q  <= res_st_d;
    res_fnd_q <= res_fnd_d;
    res_key_q <= res_key_d;
    res_pay_q <= res_pay_d;
    res_idx_q <= res_idx_d;
    if (out_load) begin
      ost_q  <= res_st_q;
      ofnd_q <= res_fnd_q;
      okey_q <= res_key_q;
      opay_q <= res_pay_q;
      oidx_q <= res_idx_ext[IW-1:0];
      ocnt_q <= cnt_out_ext[NW-1:0];
    end
  end

  assign rsp_o.valid       = ovalid_q;
  assign rsp_o.status      = ost_q;
  assign rsp_o.found       = ofnd_q;
  assign rsp_o.key_out     = okey_q;
  assign rsp_o.payload_out = opay_q;
  assign rsp_o.index_out   = oidx_q;
  assign rsp_o.count       = ocnt_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("record count above capacity");

  a_search_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SRCH) |-> (lo_q <= hi_q))
    else $error("search bounds crossed");

  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovalid_q) |-> ($past(state_q) == S_RESP))
    else $error("response raised outside result state");

  a_shift_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_SHUP) || (state_q == S_SHDN)) |-> (ptr_q < cnt_q))
    else $error("shift pointer past last record");

endmodule

`default_nettype wire
